/* hdl/cts_pkg.sv */
// ----------------------------------------------------------------------------
// Completion time summary package
// Shared widths, rank constants and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

	localparam int TIME_BITS     = 48;
	localparam int CNT_BITS      = 16;
	localparam int SUM_BITS      = 64;
	localparam int MAX_FLOWS_DEF = 1024;
	localparam int PM_BITS       = 10;
	localparam int RANK_DIV      = 1000;
	localparam int RANK_ROUND    = 999;
	localparam int PM_P50        = 500;
	localparam int PM_P90        = 900;
	localparam int PM_P99        = 990;
	localparam int N_RANKS       = 3;
	localparam int N_PICKS       = 5;

	// ceil(2^RECIP_SHIFT / RANK_DIV), exact for rank products below 2^26
	localparam int                    RECIP_SHIFT = 36;
	localparam int                    RECIP_BITS  = 27;
	localparam logic [RECIP_BITS-1:0] RANK_RECIP  = 27'd68719477;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_PUT,
		ST_DIV,
		ST_WAIT,
		ST_PICK,
		ST_OUT
	} cts_state_t;

	function automatic logic [PM_BITS-1:0] rank_permille(input logic [1:0] sel);
		logic [PM_BITS-1:0] pm;
		case (sel)
			2'd0:    pm = PM_BITS'(PM_P50);
			2'd1:    pm = PM_BITS'(PM_P90);
			default: pm = PM_BITS'(PM_P99);
		endcase
		return pm;
	endfunction

endpackage

`default_nettype wire

/* hdl/cts_store.sv */
// ----------------------------------------------------------------------------
// Completion time store
// Single write port, single registered read port holding the sorted times.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_store
	import cts_pkg::*;
#(
	parameter int DEPTH  = MAX_FLOWS_DEF,
	parameter int ADDR_W = 10
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [ADDR_W-1:0]    waddr,
	input  wire logic [TIME_BITS-1:0] wdata,
	input  wire logic [ADDR_W-1:0]    raddr,
	output logic      [TIME_BITS-1:0] rdata
);

	logic [TIME_BITS-1:0] mem [DEPTH];
	logic [TIME_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hdl/cts_divider.sv */
// ----------------------------------------------------------------------------
// Mean divider
// Restoring radix-2 divider, one quotient bit per cycle, used for the
// mean of the stored times.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_divider
	import cts_pkg::*;
#(
	parameter int DIV_W = 11
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [SUM_BITS-1:0] dividend,
	input  wire logic [DIV_W-1:0]    divisor,
	output logic                     done,
	output logic      [SUM_BITS-1:0] quotient
);

	localparam int STEP_W = $clog2(SUM_BITS + 1);

	logic [DIV_W-1:0]    rem_q;
	logic [DIV_W-1:0]    dvs_q;
	logic [SUM_BITS-1:0] quo_q;
	logic [STEP_W-1:0]   step_q;
	logic                run_q;
	logic                done_q;
	logic [DIV_W:0]      shifted;
	logic [DIV_W:0]      diff;
	logic                ge;

	always_comb begin
		shifted = {rem_q, quo_q[SUM_BITS-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = (shifted >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(SUM_BITS);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[SUM_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* hdl/completion_time_summary_core.sv */
// ----------------------------------------------------------------------------
// Completion time summary core
// Counts flow records, keeps completed times sorted and reports counts,
// min, max, nearest-rank p50/p90/p99 and floored mean on the last record.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   A record that is not completed, or whose time is dropped because the
//   store is full, and that is not last, is taken without leaving idle;
//   busy stays low. A completed record is inserted into a sorted memory
//   by walking down from the top entry, one entry per cycle on the single
//   write port; into an empty store it is written directly.
//   On the last record each of the three ranks is formed from a product,
//   then a reciprocal multiply; the divider then gives the mean, and the
//   statistics are read from the memory in turn: min, max and the three
//   ranks, after which valid is raised. When no completed times are
//   stored, valid follows the last record directly.
//   The summary is shown for exactly one cycle with valid high; the
//   receiver cannot stall it. Counts, sum and overflow flag then clear.
//   Reset clears all control state and counts; the memory is not cleared,
//   only entries below the stored count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module completion_time_summary_core
	import cts_pkg::*;
#(
	parameter int MAX_FLOWS = MAX_FLOWS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 flow_done,
	input  wire logic [TIME_BITS-1:0] flow_time_ns,
	input  wire logic                 last_flow,
	output logic                      valid,
	output logic      [CNT_BITS-1:0]  total_flows,
	output logic      [CNT_BITS-1:0]  done_flows,
	output logic      [CNT_BITS-1:0]  open_flows,
	output logic      [TIME_BITS-1:0] min_time,
	output logic      [TIME_BITS-1:0] max_time,
	output logic      [TIME_BITS-1:0] median_time,
	output logic      [TIME_BITS-1:0] p90_time,
	output logic      [TIME_BITS-1:0] p99_time,
	output logic      [TIME_BITS-1:0] mean_time,
	output logic                      overflowed
);

	localparam int AW    = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
	localparam int CW    = $clog2(MAX_FLOWS + 1);
	localparam int DIV_W = CW;
	localparam int PW    = $clog2(N_PICKS + 1);
	localparam int RW    = PM_BITS + CW;
	localparam int QW    = RW + RECIP_BITS - RECIP_SHIFT;

	cts_state_t state_q, state_d;

	logic [CNT_BITS-1:0]  flow_q;
	logic [CNT_BITS-1:0]  done_q;
	logic [CW-1:0]        stored_q;
	logic [SUM_BITS-1:0]  sum_q;
	logic                 ovf_q;
	logic [TIME_BITS-1:0] t_q;
	logic                 last_q;
	logic [CW-1:0]        i_q;
	logic [1:0]           j_q;
	logic [PW-1:0]        pick_q;
	logic [AW-1:0]        rank_q [N_RANKS];
	logic [TIME_BITS-1:0] val_q  [N_PICKS];
	logic [TIME_BITS-1:0] mean_q;
	logic [RW-1:0]        rank_x_q;

	logic                 accept;
	logic                 room;
	logic                 ins_go;
	logic                 walk_on;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [TIME_BITS-1:0] wdata;
	logic [CW-1:0]        rd_cnt;
	logic [TIME_BITS-1:0] rdata;
	logic                 div_start;
	logic [SUM_BITS-1:0]  div_dividend;
	logic [DIV_W-1:0]     div_divisor;
	logic                 div_done;
	logic [SUM_BITS-1:0]  div_quo;
	logic [PM_BITS+CW-1:0] rank_prod;
	logic [RW+RECIP_BITS-1:0] rank_mul;
	logic [QW-1:0]        rank_quo;
	logic [CW-1:0]        rank_val;
	logic [CW-1:0]        rank_m1;
	logic                 step_done;
	logic                 have_times;

	assign accept    = start && (state_q == ST_IDLE);
	assign room      = (stored_q < CW'(MAX_FLOWS));
	assign ins_go    = accept && flow_done && room;
	assign walk_on   = (rdata > t_q);
	assign step_done = (j_q != 2'(N_RANKS)) || div_done;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (ins_go && (stored_q != '0)) begin
						state_d = ST_INS;
					end else if (last_flow) begin
						state_d = ST_DIV;
					end
				end
			end
			ST_INS: begin
				if (walk_on && (i_q == CW'(1))) begin
					state_d = ST_PUT;
				end else if (!walk_on) begin
					state_d = last_q ? ST_DIV : ST_IDLE;
				end
			end
			ST_PUT:  state_d = last_q ? ST_DIV : ST_IDLE;
			ST_DIV:  state_d = (stored_q != '0) ? ST_WAIT : ST_OUT;
			ST_WAIT: begin
				if (step_done) begin
					state_d = (j_q == 2'(N_RANKS)) ? ST_PICK : ST_DIV;
				end
			end
			ST_PICK: begin
				if (pick_q == PW'(N_PICKS)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory ports and divider operands
	always_comb begin
		we     = 1'b0;
		waddr  = i_q[AW-1:0];
		wdata  = t_q;
		rd_cnt = stored_q - 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (ins_go && (stored_q == '0)) begin
					we    = 1'b1;
					waddr = '0;
					wdata = flow_time_ns;
				end
			end
			ST_INS: begin
				we     = 1'b1;
				wdata  = walk_on ? rdata : t_q;
				rd_cnt = i_q - CW'(2);
			end
			ST_PUT: begin
				we    = 1'b1;
				waddr = '0;
			end
			ST_PICK: begin
				case (pick_q)
					PW'(0):  rd_cnt = '0;
					PW'(1):  rd_cnt = stored_q - 1'b1;
					PW'(2):  rd_cnt = CW'(rank_q[0]);
					PW'(3):  rd_cnt = CW'(rank_q[1]);
					default: rd_cnt = CW'(rank_q[2]);
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		rank_prod = {{CW{1'b0}}, rank_permille(j_q)} * {{PM_BITS{1'b0}}, stored_q};
		rank_mul  = {{RECIP_BITS{1'b0}}, rank_x_q} * {{RW{1'b0}}, RANK_RECIP};
		rank_quo  = rank_mul[RW+RECIP_BITS-1:RECIP_SHIFT];
		div_start    = (state_q == ST_DIV) && (stored_q != '0) && (j_q == 2'(N_RANKS));
		div_dividend = sum_q;
		div_divisor  = DIV_W'(stored_q);
		if (rank_quo == '0) begin
			rank_val = CW'(1);
		end else if (rank_quo > QW'(stored_q)) begin
			rank_val = stored_q;
		end else begin
			rank_val = rank_quo[CW-1:0];
		end
		rank_m1 = rank_val - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			flow_q   <= '0;
			done_q   <= '0;
			stored_q <= '0;
			sum_q    <= '0;
			ovf_q    <= 1'b0;
			last_q   <= 1'b0;
			j_q      <= '0;
			pick_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= last_flow;
						j_q    <= '0;
						if (flow_q != '1) begin
							flow_q <= flow_q + 1'b1;
						end
						if (flow_done) begin
							if (done_q != '1) begin
								done_q <= done_q + 1'b1;
							end
							if (room) begin
								stored_q <= stored_q + 1'b1;
								sum_q    <= sum_q + SUM_BITS'(flow_time_ns);
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end
				end
				ST_WAIT: begin
					if (step_done) begin
						j_q    <= j_q + 1'b1;
						pick_q <= '0;
					end
				end
				ST_PICK: pick_q <= pick_q + 1'b1;
				ST_OUT: begin
					flow_q   <= '0;
					done_q   <= '0;
					stored_q <= '0;
					sum_q    <= '0;
					ovf_q    <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			t_q <= flow_time_ns;
			i_q <= stored_q;
		end else if ((state_q == ST_INS) && walk_on) begin
			i_q <= i_q - 1'b1;
		end
		if ((state_q == ST_DIV) && (j_q != 2'(N_RANKS))) begin
			rank_x_q <= rank_prod + RW'(RANK_ROUND);
		end
		if ((state_q == ST_WAIT) && step_done) begin
			if (j_q == 2'(N_RANKS)) begin
				mean_q <= div_quo[TIME_BITS-1:0];
			end else begin
				rank_q[j_q] <= rank_m1[AW-1:0];
			end
		end
		if ((state_q == ST_PICK) && (pick_q != '0)) begin
			val_q[pick_q - 1'b1] <= rdata;
		end
	end

	cts_store #(
		.DEPTH  (MAX_FLOWS),
		.ADDR_W (AW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_cnt[AW-1:0]),
		.rdata (rdata)
	);

	cts_divider #(
		.DIV_W (DIV_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// outputs
	assign have_times  = (stored_q != '0);
	assign busy        = (state_q != ST_IDLE);
	assign valid       = (state_q == ST_OUT);
	assign total_flows = flow_q;
	assign done_flows  = done_q;
	assign open_flows  = flow_q - done_q;
	assign min_time    = have_times ? val_q[0] : '0;
	assign max_time    = have_times ? val_q[1] : '0;
	assign median_time = have_times ? val_q[2] : '0;
	assign p90_time    = have_times ? val_q[3] : '0;
	assign p99_time    = have_times ? val_q[4] : '0;
	assign mean_time   = have_times ? mean_q : '0;
	assign overflowed  = ovf_q;

endmodule

`default_nettype wire
